@@ src/two_axis_pid_velocity_core_defines.svh @@
// Assertion macros used by the checker file of this block.
`ifndef TWO_AXIS_PID_VELOCITY_CORE_DEFINES_SVH
`define TWO_AXIS_PID_VELOCITY_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPVC_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tpvc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TPVC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tpvc assertion failed");

`endif

@@ src/tpvc_pkg.sv @@
package tpvc_pkg;

    localparam int POS_W    = 16;
    localparam int ERR_W    = 17;
    localparam int DIFF_W   = 18;
    localparam int DERIV_W  = 34;
    localparam int INTEG_W  = 48;
    localparam int OPA_W    = 25;
    localparam int OPB_W    = 16;
    localparam int PROD_W   = 41;
    localparam int ACC_W    = 68;
    localparam int LIM_W    = 15;
    localparam int STEP_W   = 4;
    localparam int VEL_SHIFT = 28;

    // Last micro-step of one axis.
    localparam logic [STEP_W-1:0] STEP_LAST = 4'd9;

    typedef enum logic [2:0] {
        REG_TARGET_X      = 3'd0,
        REG_TARGET_Y      = 3'd1,
        REG_GAIN_P        = 3'd2,
        REG_GAIN_I        = 3'd3,
        REG_GAIN_D        = 3'd4,
        REG_SAMPLE_PERIOD = 3'd5,
        REG_SAMPLE_RATE   = 3'd6,
        REG_VEL_LIMIT     = 3'd7
    } reg_index_t;

    typedef enum logic [2:0] {
        MS_ERR_PER   = 3'd0,
        MS_DIFF_RATE = 3'd1,
        MS_GP_ERR    = 3'd2,
        MS_GI_ILO    = 3'd3,
        MS_GI_IHI    = 3'd4,
        MS_GD_DLO    = 3'd5,
        MS_GD_DHI    = 3'd6
    } mul_sel_t;

    typedef enum logic [1:0] {
        AO_HOLD       = 2'd0,
        AO_LOAD_INTEG = 2'd1,
        AO_LOAD       = 2'd2,
        AO_ADD        = 2'd3
    } acc_op_t;

    typedef enum logic [1:0] {
        SH_0  = 2'd0,
        SH_16 = 2'd1,
        SH_24 = 2'd2,
        SH_33 = 2'd3
    } shift_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        shift_t   shift;
        logic     err_wr;
        logic     integ_wr;
        logic     deriv_wr;
        logic     res_wr;
    } step_ctl_t;

    typedef struct packed {
        step_ctl_t step;
        logic      axis;
        logic      out_load;
        logic      in_ready;
    } seq_t;

    localparam step_ctl_t STEP_IDLE = '{
        mul_sel: MS_ERR_PER, acc_op: AO_HOLD, shift: SH_0,
        err_wr: 1'b0, integ_wr: 1'b0, deriv_wr: 1'b0, res_wr: 1'b0
    };

    // Micro-program of one axis. A product issued in step k is
    // registered and consumed by the accumulator in step k+1.
    function automatic step_ctl_t step_ctl(input logic [STEP_W-1:0] s);
        step_ctl_t c;
        c = STEP_IDLE;
        unique case (s)
            4'd0: c.err_wr = 1'b1;
            4'd1: c.mul_sel = MS_ERR_PER;
            4'd2:
            begin
                c.mul_sel = MS_DIFF_RATE;
                c.acc_op  = AO_LOAD_INTEG;
            end
            4'd3:
            begin
                c.mul_sel  = MS_GP_ERR;
                c.integ_wr = 1'b1;
                c.deriv_wr = 1'b1;
            end
            4'd4:
            begin
                c.mul_sel = MS_GI_ILO;
                c.acc_op  = AO_LOAD;
                c.shift   = SH_16;
            end
            4'd5:
            begin
                c.mul_sel = MS_GI_IHI;
                c.acc_op  = AO_ADD;
                c.shift   = SH_0;
            end
            4'd6:
            begin
                c.mul_sel = MS_GD_DLO;
                c.acc_op  = AO_ADD;
                c.shift   = SH_24;
            end
            4'd7:
            begin
                c.mul_sel = MS_GD_DHI;
                c.acc_op  = AO_ADD;
                c.shift   = SH_16;
            end
            4'd8:
            begin
                c.acc_op = AO_ADD;
                c.shift  = SH_33;
            end
            4'd9: c.res_wr = 1'b1;
            default: c = STEP_IDLE;
        endcase
        return c;
    endfunction

endpackage

@@ src/tpvc_mac.sv @@
module tpvc_mac
    import tpvc_pkg::*;
(
    input  logic                      clk,
    input  step_ctl_t                 ctl,
    input  logic signed [OPA_W-1:0]   op_a,
    input  logic        [OPB_W-1:0]   op_b,
    input  logic signed [INTEG_W-1:0] integ_in,
    output logic signed [PROD_W-1:0]  prod,
    output logic signed [ACC_W-1:0]   acc
);

    logic signed [PROD_W:0]    mul_full;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   prod_sh;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;

    assign mul_full  = op_a * $signed({1'b0, op_b});
    assign prod_next = mul_full[PROD_W-1:0];
    assign prod_ext  = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_comb
    begin
        unique case (ctl.shift)
            SH_0:    prod_sh = prod_ext;
            SH_16:   prod_sh = prod_ext <<< 16;
            SH_24:   prod_sh = prod_ext <<< 24;
            SH_33:   prod_sh = prod_ext <<< 33;
            default: prod_sh = prod_ext;
        endcase
    end

    always_comb
    begin
        unique case (ctl.acc_op)
            AO_HOLD:       acc_next = acc_reg;
            AO_LOAD_INTEG: acc_next = {{(ACC_W-INTEG_W){integ_in[INTEG_W-1]}}, integ_in}
                                      + prod_ext;
            AO_LOAD:       acc_next = prod_sh;
            AO_ADD:        acc_next = acc_reg + prod_sh;
            default:       acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

@@ src/tpvc_ctrl.sv @@
module tpvc_ctrl
    import tpvc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic out_busy,
    output seq_t seq
);

    state_t              state_reg;
    state_t              state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic                axis_reg;
    logic                axis_next;

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        axis_next     = axis_reg;
        seq.step      = STEP_IDLE;
        seq.axis      = axis_reg;
        seq.out_load  = 1'b0;
        seq.in_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                seq.in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_RUN;
                    step_next  = '0;
                    axis_next  = 1'b0;
                end
            end
            ST_RUN:
            begin
                seq.step = step_ctl(step_reg);
                if (step_reg == STEP_LAST)
                begin
                    step_next = '0;
                    if (axis_reg)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        axis_next = 1'b1;
                    end
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_OUT:
            begin
                if (!out_busy)
                begin
                    seq.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            axis_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            axis_reg  <= axis_next;
        end
    end

endmodule

@@ src/two_axis_pid_velocity_core.sv @@
// Position items are taken only while the controller is idle, after the previous result has
// moved into the output register; each axis takes ten steps of the single shared
// multiply-accumulate unit, which carries every product of the PID step in turn.
// Reset (rst_n low, asynchronous) clears both integrators and previous errors, drops
// m_axis_tvalid and loads the configuration registers with their documented defaults.
module two_axis_pid_velocity_core
    import tpvc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Position sample item.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] pos_x, [31:16] pos_y
    // Velocity command item.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] vel_x, [31:16] vel_y
    output logic [1:0]  m_axis_tuser,   // [0] x_clamped, [1] y_clamped
    // Configuration writes, taken in any cycle.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // Configuration registers.
    logic signed [POS_W-1:0] target_x_reg;
    logic signed [POS_W-1:0] target_y_reg;
    logic [15:0]             gain_p_reg;
    logic [15:0]             gain_i_reg;
    logic [15:0]             gain_d_reg;
    logic [15:0]             sample_period_reg;
    logic [15:0]             sample_rate_reg;
    logic [LIM_W-1:0]        vel_limit_reg;

    // Per-axis controller state.
    logic signed [INTEG_W-1:0] integ_x_reg;
    logic signed [INTEG_W-1:0] integ_y_reg;
    logic signed [ERR_W-1:0]   prev_err_x_reg;
    logic signed [ERR_W-1:0]   prev_err_y_reg;

    // Working registers of the current item.
    logic signed [POS_W-1:0]   pos_x_reg;
    logic signed [POS_W-1:0]   pos_y_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic signed [DERIV_W-1:0] deriv_reg;
    logic signed [POS_W-1:0]   vel_x_reg;
    logic signed [POS_W-1:0]   vel_y_reg;
    logic                      clamp_x_reg;
    logic                      clamp_y_reg;

    // Output stage.
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [31:0]               out_data_reg;
    logic [1:0]                out_user_reg;

    seq_t                      seq;
    logic                      in_accept;

    logic signed [POS_W-1:0]   target_cur;
    logic signed [POS_W-1:0]   pos_cur;
    logic signed [INTEG_W-1:0] integ_cur;
    logic signed [ERR_W-1:0]   prev_err_cur;
    logic signed [ERR_W-1:0]   err_next;
    logic signed [DIFF_W-1:0]  diff_next;

    logic signed [OPA_W-1:0]   op_a;
    logic        [OPB_W-1:0]   op_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [ACC_W-1:0]   acc;

    logic signed [INTEG_W-1:0] integ_next;
    logic signed [ACC_W-VEL_SHIFT-1:0] vel_raw;
    logic signed [ACC_W-VEL_SHIFT-1:0] lim_pos;
    logic signed [ACC_W-VEL_SHIFT-1:0] lim_neg;
    logic signed [POS_W-1:0]   vel_next;
    logic                      clamp_next;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = seq.in_ready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    tpvc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .out_busy (out_valid_reg && !m_axis_tready),
        .seq      (seq)
    );

    // Configuration writes. Every index of the three-bit port names a register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_x_reg      <= 16'sd2560;
            target_y_reg      <= 16'sd2560;
            gain_p_reg        <= 16'd2048;
            gain_i_reg        <= 16'd410;
            gain_d_reg        <= 16'd410;
            sample_period_reg <= 16'd655;
            sample_rate_reg   <= 16'd100;
            vel_limit_reg     <= 15'd2560;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TARGET_X:      target_x_reg      <= cfg_data;
                REG_TARGET_Y:      target_y_reg      <= cfg_data;
                REG_GAIN_P:        gain_p_reg        <= cfg_data;
                REG_GAIN_I:        gain_i_reg        <= cfg_data;
                REG_GAIN_D:        gain_d_reg        <= cfg_data;
                REG_SAMPLE_PERIOD: sample_period_reg <= cfg_data;
                REG_SAMPLE_RATE:   sample_rate_reg   <= cfg_data;
                REG_VEL_LIMIT:     vel_limit_reg     <= cfg_data[LIM_W-1:0];
                default:           target_x_reg      <= target_x_reg;
            endcase
        end
    end

    // The axis bit selects which set of state the shared datapath works on.
    assign target_cur   = seq.axis ? target_y_reg   : target_x_reg;
    assign pos_cur      = seq.axis ? pos_y_reg      : pos_x_reg;
    assign integ_cur    = seq.axis ? integ_y_reg    : integ_x_reg;
    assign prev_err_cur = seq.axis ? prev_err_y_reg : prev_err_x_reg;

    // Error and error difference are narrow enough to form in one step.
    assign err_next  = ERR_W'(target_cur) - ERR_W'(pos_cur);
    assign diff_next = DIFF_W'(err_next) - DIFF_W'(prev_err_cur);

    // Operand selection for the shared multiplier. The 48-bit integrator and
    // the 34-bit derivative are split into an unsigned low part and a signed
    // high part; the accumulator weights each partial product by its shift.
    always_comb
    begin
        unique case (seq.step.mul_sel)
            MS_ERR_PER:
            begin
                op_a = OPA_W'(err_reg);
                op_b = sample_period_reg;
            end
            MS_DIFF_RATE:
            begin
                op_a = OPA_W'(diff_reg);
                op_b = sample_rate_reg;
            end
            MS_GP_ERR:
            begin
                op_a = OPA_W'(err_reg);
                op_b = gain_p_reg;
            end
            MS_GI_ILO:
            begin
                op_a = $signed({1'b0, integ_cur[23:0]});
                op_b = gain_i_reg;
            end
            MS_GI_IHI:
            begin
                op_a = OPA_W'($signed(integ_cur[INTEG_W-1:24]));
                op_b = gain_i_reg;
            end
            MS_GD_DLO:
            begin
                op_a = $signed({8'd0, deriv_reg[16:0]});
                op_b = gain_d_reg;
            end
            MS_GD_DHI:
            begin
                op_a = OPA_W'($signed(deriv_reg[DERIV_W-1:17]));
                op_b = gain_d_reg;
            end
            default:
            begin
                op_a = OPA_W'(err_reg);
                op_b = sample_period_reg;
            end
        endcase
    end

    // The accumulator collects P*2^16 + I*Q + D*2^16, so one final shift by 28
    // gives the floored Q8.8 velocity, including the floor of the integral term.
    tpvc_mac u_mac (
        .clk      (clk),
        .ctl      (seq.step),
        .op_a     (op_a),
        .op_b     (op_b),
        .integ_in (integ_cur),
        .prod     (prod),
        .acc      (acc)
    );

    // Integrator saturation: the sum fits when bit 47 and all bits above it match the sign.
    always_comb
    begin
        if (acc[ACC_W-1:INTEG_W-1] == {(ACC_W-INTEG_W+1){acc[ACC_W-1]}})
        begin
            integ_next = acc[INTEG_W-1:0];
        end
        else if (acc[ACC_W-1])
        begin
            integ_next = {1'b1, {(INTEG_W-1){1'b0}}};
        end
        else
        begin
            integ_next = {1'b0, {(INTEG_W-1){1'b1}}};
        end
    end

    // Velocity clamp to plus or minus the limit; a zero limit forces zero.
    assign vel_raw = acc[ACC_W-1:VEL_SHIFT];
    assign lim_pos = $signed({{(ACC_W-VEL_SHIFT-LIM_W){1'b0}}, vel_limit_reg});
    assign lim_neg = -lim_pos;

    always_comb
    begin
        priority if (vel_raw > lim_pos)
        begin
            vel_next   = POS_W'(lim_pos);
            clamp_next = 1'b1;
        end
        else if (vel_raw < lim_neg)
        begin
            vel_next   = POS_W'(lim_neg);
            clamp_next = 1'b1;
        end
        else
        begin
            vel_next   = POS_W'(vel_raw);
            clamp_next = 1'b0;
        end
    end

    // Controller state that persists from item to item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_x_reg    <= '0;
            integ_y_reg    <= '0;
            prev_err_x_reg <= '0;
            prev_err_y_reg <= '0;
        end
        else
        begin
            if (seq.step.err_wr)
            begin
                if (seq.axis)
                begin
                    prev_err_y_reg <= err_next;
                end
                else
                begin
                    prev_err_x_reg <= err_next;
                end
            end
            if (seq.step.integ_wr)
            begin
                if (seq.axis)
                begin
                    integ_y_reg <= integ_next;
                end
                else
                begin
                    integ_x_reg <= integ_next;
                end
            end
        end
    end

    // Payload registers of the item in flight.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pos_x_reg <= s_axis_tdata[15:0];
            pos_y_reg <= s_axis_tdata[31:16];
        end
        if (seq.step.err_wr)
        begin
            err_reg  <= err_next;
            diff_reg <= diff_next;
        end
        if (seq.step.deriv_wr)
        begin
            deriv_reg <= prod[DERIV_W-1:0];
        end
        if (seq.step.res_wr)
        begin
            if (seq.axis)
            begin
                vel_y_reg   <= vel_next;
                clamp_y_reg <= clamp_next;
            end
            else
            begin
                vel_x_reg   <= vel_next;
                clamp_x_reg <= clamp_next;
            end
        end
        if (seq.out_load)
        begin
            out_data_reg <= {vel_y_reg, vel_x_reg};
            out_user_reg <= {clamp_y_reg, clamp_x_reg};
        end
    end

    // Output register: the next sample may be taken while this result waits.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (seq.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

@@ src/tpvc_checker.sv @@
`include "two_axis_pid_velocity_core_defines.svh"

module tpvc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [2:0]  cfg_index,
    input logic [15:0] cfg_data
);

    // A stalled result stays offered and unchanged.
    `TPVC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `TPVC_ASSERT_NEXT(a_out_stable, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // Once a sample is taken the block is busy with it and drops s_axis_tready.
    `TPVC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // A new result only appears at the end of a busy period.
    `TPVC_ASSERT_IMPLY(a_result_after_work, clk, rst_n, $rose(m_axis_tvalid), !$past(s_axis_tready))

endmodule

bind two_axis_pid_velocity_core tpvc_checker u_tpvc_checker (.*);

@@ verif/tb_two_axis_pid_velocity_core.sv @@
module tb_two_axis_pid_velocity_core;
    timeunit 1ns;
    timeprecision 1ps;

    import tpvc_pkg::*;

    // Saturation bounds of the 48-bit Q24.24 integrator.
    localparam longint INTEG_HI = (longint'(1) <<< 47) - 1;
    localparam longint INTEG_LO = -(longint'(1) <<< 47);

    // Long receiver hold-off used to back the block up into its input.
    localparam int LONG_HOLD_CYCLES = 400;

    // Items in the integrator soak at the fastest integration rate.
    localparam int SOAK_ITEMS = 120;

    // One velocity command as the block reports it.
    typedef struct {
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic               x_clamped;
        logic               y_clamped;
    } velocity_cmd_t;

    // Tracks the controller registers and per-axis state, predicts the velocity
    // command for each accepted position item, and checks the commands that leave
    // the block in order.
    class velocity_scoreboard;
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
        logic [15:0]        gain_p;
        logic [15:0]        gain_i;
        logic [15:0]        gain_d;
        logic [15:0]        period;
        logic [15:0]        rate;
        logic [14:0]        vel_limit;
        longint             integ_x;
        longint             integ_y;
        longint             prev_err_x;
        longint             prev_err_y;
        velocity_cmd_t      expected_cmds[$];
        int                 errors;
        int                 samples;
        int                 x_clamps;
        int                 y_clamps;
        int                 x_sat_hi;
        int                 y_sat_lo;

        function new();
            target_x   = 16'sd2560;
            target_y   = 16'sd2560;
            gain_p     = 16'd2048;
            gain_i     = 16'd410;
            gain_d     = 16'd410;
            period     = 16'd655;
            rate       = 16'd100;
            vel_limit  = 15'd2560;
            integ_x    = 0;
            integ_y    = 0;
            prev_err_x = 0;
            prev_err_y = 0;
            errors     = 0;
            samples    = 0;
            x_clamps   = 0;
            y_clamps   = 0;
            x_sat_hi   = 0;
            y_sat_lo   = 0;
        endfunction

        function void write_reg(input logic [2:0] idx, input logic [15:0] data);
            case (reg_index_t'(idx))
                REG_TARGET_X:      target_x  = data;
                REG_TARGET_Y:      target_y  = data;
                REG_GAIN_P:        gain_p    = data;
                REG_GAIN_I:        gain_i    = data;
                REG_GAIN_D:        gain_d    = data;
                REG_SAMPLE_PERIOD: period    = data;
                REG_SAMPLE_RATE:   rate      = data;
                REG_VEL_LIMIT:     vel_limit = data[14:0];
                default: ;
            endcase
        endfunction

        // One PID step of one axis. The integrator is updated before it is
        // used, and every scaling step rounds toward minus infinity.
        function void predict_axis(input longint target, input longint pos,
                                   inout longint integ, inout longint prev_err,
                                   output logic signed [15:0] vel,
                                   output logic clamped);
            longint err;
            longint acc;
            longint deriv;
            longint total;
            longint v;
            longint lim;
            err = target - pos;
            acc = integ + err * longint'(period);
            if (acc > INTEG_HI)
                acc = INTEG_HI;
            if (acc < INTEG_LO)
                acc = INTEG_LO;
            integ = acc;
            deriv = (err - prev_err) * longint'(rate);
            total = longint'(gain_p) * err
                  + ((longint'(gain_i) * acc) >>> 16)
                  + longint'(gain_d) * deriv;
            v = total >>> 12;
            lim = longint'(vel_limit);
            clamped = 1'b0;
            if (v > lim)
            begin
                v = lim;
                clamped = 1'b1;
            end
            if (v < -lim)
            begin
                v = -lim;
                clamped = 1'b1;
            end
            prev_err = err;
            vel = v[15:0];
        endfunction

        function void note_sample(input logic [31:0] tdata);
            velocity_cmd_t cmd;
            logic signed [15:0] pos_x;
            logic signed [15:0] pos_y;
            pos_x = tdata[15:0];
            pos_y = tdata[31:16];
            predict_axis(longint'(target_x), longint'(pos_x), integ_x, prev_err_x,
                         cmd.vel_x, cmd.x_clamped);
            predict_axis(longint'(target_y), longint'(pos_y), integ_y, prev_err_y,
                         cmd.vel_y, cmd.y_clamped);
            if (integ_x == INTEG_HI)
                x_sat_hi++;
            if (integ_y == INTEG_LO)
                y_sat_lo++;
            samples++;
            expected_cmds.push_back(cmd);
        endfunction

        function int pending();
            return expected_cmds.size();
        endfunction

        task report_mismatch(input string msg);
            errors++;
            if (errors <= 20)
                $display("MISMATCH at %0t ns: %s", $time, msg);
        endtask

        task check_result(input logic [31:0] tdata, input logic [1:0] tuser);
            velocity_cmd_t want;
            if (expected_cmds.size() == 0)
            begin
                report_mismatch($sformatf("velocity item with nothing expected, data %h", tdata));
                return;
            end
            want = expected_cmds.pop_front();
            if (tdata[15:0] !== want.vel_x)
                report_mismatch($sformatf("vel_x got %h want %h", tdata[15:0], want.vel_x));
            if (tdata[31:16] !== want.vel_y)
                report_mismatch($sformatf("vel_y got %h want %h", tdata[31:16], want.vel_y));
            if (tuser[0] !== want.x_clamped)
                report_mismatch($sformatf("x_clamped got %b want %b", tuser[0], want.x_clamped));
            if (tuser[1] !== want.y_clamped)
                report_mismatch($sformatf("y_clamped got %b want %b", tuser[1], want.y_clamped));
            if (want.x_clamped)
                x_clamps++;
            if (want.y_clamped)
                y_clamps++;
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    // Requests from the stimulus to the receiver process.
    logic        hold_request;
    logic        rx_free;

    int          phases;

    velocity_scoreboard sb = new();

    two_axis_pid_velocity_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // All handshakes are observed at the rising edge, before the block's own
    // registers update. Configuration writes and position items update the
    // predictor at the edge where they are accepted, so the expected commands
    // always see the register values the block had for that item.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_sample(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    // Receiver. It switches between always-ready, coin-flip and a rotating
    // bit pattern, each for a random stretch, so stalls land on every phase of
    // the block's step sequence. A hold request drops tready for a long count
    // so that the output backs up and the block refuses new position items.
    initial
    begin : receiver
        int          mode;
        int          mode_left;
        logic [31:0] pattern;
        int          pat_pos;
        mode = 0;
        mode_left = 0;
        pattern = '1;
        pat_pos = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_axis_tready = 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (rx_free)
            begin
                m_axis_tready = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(30, 300);
                    pattern = $urandom;
                end
                mode_left--;
                case (mode)
                    0: m_axis_tready = 1'b1;
                    1: m_axis_tready = 1'($urandom_range(0, 1));
                    default:
                    begin
                        m_axis_tready = pattern[pat_pos];
                        pat_pos = (pat_pos + 1) % 32;
                    end
                endcase
            end
        end
    end

    // Hard stop in case the block hangs. The slowest correct run is well under
    // a fifth of this.
    initial
    begin
        #60_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Every driving task starts and ends just after a falling edge.

    task automatic cfg_write(input reg_index_t idx, input logic [15:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_sample(input logic [15:0] pos_x, input logic [15:0] pos_y);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {pos_y, pos_x};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Waits until every predicted command has come back; registers may only be
    // written while the block is idle.
    task automatic wait_drained();
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic load_config(input logic [15:0] tx, input logic [15:0] ty,
                               input logic [15:0] gp, input logic [15:0] gi,
                               input logic [15:0] gd, input logic [15:0] per,
                               input logic [15:0] rt, input logic [15:0] lim);
        wait_drained();
        cfg_write(REG_TARGET_X, tx);
        cfg_write(REG_TARGET_Y, ty);
        cfg_write(REG_GAIN_P, gp);
        cfg_write(REG_GAIN_I, gi);
        cfg_write(REG_GAIN_D, gd);
        cfg_write(REG_SAMPLE_PERIOD, per);
        cfg_write(REG_SAMPLE_RATE, rt);
        cfg_write(REG_VEL_LIMIT, lim);
        phases++;
    endtask

    // Register value biased toward the corners of the 16-bit range.
    function automatic logic [15:0] pick_reg();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h7FFF;
            3: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Gain, period or rate: usually modest so the commands stay in range,
    // sometimes at a corner.
    function automatic logic [15:0] pick_scale();
        if ($urandom_range(0, 1) == 0)
            return 16'($urandom_range(0, 4095));
        return pick_reg();
    endfunction

    // Position near the target most of the time, so the loop stays out of the
    // clamp often enough, with full-range and corner values mixed in.
    function automatic logic [15:0] pick_pos(input logic [15:0] target);
        case ($urandom_range(0, 7))
            0: return pick_reg();
            1, 2: return 16'($urandom);
            default: return target + 16'($urandom_range(0, 127)) - 16'd64;
        endcase
    endfunction

    // Random position items in bursts of random length. Gaps between bursts
    // are random, and some bursts run straight into the next with no gap.
    task automatic send_items(input int count, input bit with_gaps);
        int left;
        int burst;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 24);
            if (burst > left)
                burst = left;
            repeat (burst)
            begin
                send_sample(pick_pos(sb.target_x), pick_pos(sb.target_y));
                left--;
            end
            if (with_gaps && $urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 30)) @(negedge clk);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_TARGET_X;
        cfg_data      = '0;
        hold_request  = 1'b0;
        rx_free       = 1'b0;
        phases        = 1;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed items under the reset configuration. The first one runs
        // with a zero previous error, so its derivative is the whole error
        // times the rate. Then zero error, the field corners, opposite corners
        // on the two axes and alternating bit patterns.
        send_sample(16'h0000, 16'h0000);
        send_sample(16'd2560, 16'd2560);
        send_sample(16'd2560, 16'd2560);
        send_sample(16'h7FFF, 16'h8000);
        send_sample(16'h8000, 16'h7FFF);
        send_sample(16'h7FFF, 16'h7FFF);
        send_sample(16'h8000, 16'h8000);
        send_sample(16'hFFFF, 16'hFFFF);
        send_sample(16'h0001, 16'h0000);
        send_sample(16'd2559, 16'd2561);
        send_sample(16'h5555, 16'hAAAA);
        send_sample(16'hAAAA, 16'h5555);
        send_sample(16'd2816, 16'd2304);
        send_sample(16'd2560, 16'd2560);

        // Zero period holds the integrator and zero rate removes the
        // derivative, with every gain at full scale and extreme targets.
        load_config(16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'h0000, 16'h0000, 16'h7FFF);
        send_sample(16'h7FFF, 16'h8000);
        send_sample(16'h8000, 16'h7FFF);
        send_items(150, 1'b1);

        // Zero limit: every command is zero and the flag tells whether the
        // unclamped value was nonzero. Writing 16'h8000 also sets the bit
        // above the limit field, which the block drops.
        load_config(16'h0100, 16'hFF00, 16'd4096, 16'd0, 16'd0,
                    16'd655, 16'd100, 16'h8000);
        send_sample(16'h0100, 16'hFF00);
        send_sample(16'h0101, 16'hFF00);
        send_items(150, 1'b1);

        // Random settings. In the third one the receiver holds off for a long
        // stretch while items keep coming with no gaps, so the block stalls its
        // input; in the fifth the sender waits halfway for all commands to
        // come back before going on.
        for (int p = 0; p < 8; p++)
        begin
            load_config(pick_reg(), pick_reg(), pick_scale(),
                        ($urandom_range(0, 2) == 0) ? 16'h0000 : pick_scale(),
                        pick_scale(), pick_scale(), pick_scale(), pick_reg());
            if (p == 2)
            begin
                hold_request = 1'b1;
                send_items(40, 1'b0);
                send_items(100, 1'b1);
            end
            else if (p == 4)
            begin
                send_items(70, 1'b1);
                wait_drained();
                send_items(70, 1'b1);
            end
            else
            begin
                send_items(140, 1'b1);
            end
        end

        // Integrator soak: the largest error times the largest period on every
        // item pushes x upward and y downward as fast as the integrators can
        // move. It runs last because the large integrators would otherwise
        // dominate every later command.
        load_config(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0000,
                    16'hFFFF, 16'hFFFF, 16'h7FFF);
        rx_free = 1'b1;
        repeat (SOAK_ITEMS) send_sample(16'h8000, 16'h7FFF);
        rx_free = 1'b0;
        send_items(60, 1'b1);

        wait_drained();
        repeat (30) @(negedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d commands never arrived", sb.pending()));

        $display("Covered %0d position items over %0d register settings, with %0d x and %0d y",
                 sb.samples, phases, sb.x_clamps, sb.y_clamps);
        $display("commands clamped; integrators sat at their bounds for %0d x and %0d y items.",
                 sb.x_sat_hi, sb.y_sat_lo);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
